>>> sv/spi_master_byte_engine_top_assert.svh
// Assertion macros used by the checker file of the SPI master byte engine.
`ifndef SPI_MASTER_BYTE_ENGINE_TOP_ASSERT_SVH
`define SPI_MASTER_BYTE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define SPI_MBE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spi master byte engine: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define SPI_MBE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spi master byte engine: next-cycle check failed");

`endif

>>> sv/spi_mbe_pkg.sv
// Types and constants shared by the SPI master byte engine files.
package spi_mbe_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned HALF_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Request codes.
  localparam logic [1:0] REQ_IDLE    = 2'd0;
  localparam logic [1:0] REQ_BYTE    = 2'd1;
  localparam logic [1:0] REQ_SEL     = 2'd2;
  localparam logic [1:0] REQ_RELEASE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HALF = 1'd1;

  typedef struct packed {
    logic [1:0]        clk_mode;
    logic [HALF_W-1:0] half_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic              sck;
    logic              mosi;
    logic              cs_n;
    logic              busy_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_valid;
    logic              req_dropped;
  } result_t;

endpackage

>>> sv/spi_mbe_in_if.sv
// Request channel of the SPI master byte engine.
interface spi_mbe_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     req_type;
  logic [spi_mbe_pkg::BYTE_W-1:0] tx_byte;
  logic                           miso;

  modport source (output valid, output req_type, output tx_byte, output miso, input ready);
  modport sink (input valid, input req_type, input tx_byte, input miso, output ready);
endinterface

>>> sv/spi_mbe_out_if.sv
// Result channel of the SPI master byte engine.
interface spi_mbe_out_if;
  logic                           valid;
  logic                           ready;
  logic                           sck;
  logic                           mosi;
  logic                           cs_n;
  logic                           busy_res;
  logic [spi_mbe_pkg::BYTE_W-1:0] rx_byte;
  logic                           rx_valid;
  logic                           req_dropped;

  modport source (output valid, output sck, output mosi, output cs_n, output busy_res,
                  output rx_byte, output rx_valid, output req_dropped, input ready);
  modport sink (input valid, input sck, input mosi, input cs_n, input busy_res,
                input rx_byte, input rx_valid, input req_dropped, output ready);
endinterface

>>> sv/spi_mbe_cfg_if.sv
// Configuration write channel of the SPI master byte engine.
interface spi_mbe_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [spi_mbe_pkg::CFG_IDX_W-1:0] index;
  logic [spi_mbe_pkg::HALF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/spi_master_byte_engine_top.sv
// SPI master byte engine top level: configuration registers, sequencer and result register.
// Each accepted request beat is one tick of an SPI master (modes 0 to 3, MSB first), and
// one beat is taken every clock cycle unless the request channel stalls. The sequencer's
// state registers and next-state logic finish a tick per accepted beat; the pin levels
// and status for that tick appear in the result register in the cycle after acceptance. The
// request channel stalls only while the result register holds a beat that the sink has
// not taken. Configuration writes are always taken and apply from the next request beat.
module spi_master_byte_engine_top (
  input  logic          clk,
  input  logic          rst_n,
  spi_mbe_in_if.sink    in_ch,
  spi_mbe_out_if.source out_ch,
  spi_mbe_cfg_if.sink   cfg_ch
);

  spi_mbe_pkg::cfg_t    cfg_r;
  spi_mbe_pkg::result_t step_res;
  spi_mbe_pkg::result_t res_r;
  logic                 out_valid_r;
  logic                 in_fire;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clk_mode          <= 2'd0;
      cfg_r.half_period_ticks <= spi_mbe_pkg::HALF_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        spi_mbe_pkg::CFG_IDX_MODE: cfg_r.clk_mode          <= cfg_ch.data[1:0];
        spi_mbe_pkg::CFG_IDX_HALF: cfg_r.half_period_ticks <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  spi_mbe_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (in_fire),
    .cfg      (cfg_r),
    .req_type (in_ch.req_type),
    .tx_byte  (in_ch.tx_byte),
    .miso     (in_ch.miso),
    .res      (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= step_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sck         = res_r.sck;
  assign out_ch.mosi        = res_r.mosi;
  assign out_ch.cs_n        = res_r.cs_n;
  assign out_ch.busy_res    = res_r.busy_res;
  assign out_ch.rx_byte     = res_r.rx_byte;
  assign out_ch.rx_valid    = res_r.rx_valid;
  assign out_ch.req_dropped = res_r.req_dropped;

endmodule

>>> sv/spi_mbe_seq.sv
// Bit-level sequencer: state registers and the single-tick next-state logic.
module spi_mbe_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_en,
  input  spi_mbe_pkg::cfg_t              cfg,
  input  logic [1:0]                     req_type,
  input  logic [spi_mbe_pkg::BYTE_W-1:0] tx_byte,
  input  logic                           miso,
  output spi_mbe_pkg::result_t           res
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_A0_LEAD  = 3'd1;
  localparam logic [2:0] PH_A0_TRAIL = 3'd2;
  localparam logic [2:0] PH_A1_TRAIL = 3'd3;
  localparam logic [2:0] PH_A1_GAP   = 3'd4;
  localparam logic [2:0] PH_CS_SETUP = 3'd5;
  localparam logic [2:0] PH_CS_HOLD  = 3'd6;
  localparam logic [2:0] PH_CS_IDLE  = 3'd7;

  localparam logic [2:0] LAST_BIT = 3'd7;

  logic [spi_mbe_pkg::BYTE_W-1:0] tx_shift_r, tx_shift_nxt;
  logic [spi_mbe_pkg::BYTE_W-1:0] rx_shift_r, rx_shift_nxt;
  logic [2:0]                     bit_idx_r, bit_idx_nxt;
  logic [2:0]                     phase_r, phase_nxt;
  logic [spi_mbe_pkg::HALF_W-1:0] wait_cnt_r, wait_cnt_nxt;
  logic                           sck_r, sck_nxt;
  logic                           mosi_r, mosi_nxt;
  logic                           cs_n_r, cs_n_nxt;
  logic [spi_mbe_pkg::HALF_W-1:0] delay;
  logic                           rx_valid;
  logic                           dropped;
  logic [spi_mbe_pkg::BYTE_W-1:0] rx_out;

  // A half period of zero behaves as one tick.
  assign delay = (cfg.half_period_ticks == '0) ? spi_mbe_pkg::HALF_W'(1)
                                               : cfg.half_period_ticks;

  always_comb begin
    tx_shift_nxt = tx_shift_r;
    rx_shift_nxt = rx_shift_r;
    bit_idx_nxt  = bit_idx_r;
    phase_nxt    = phase_r;
    wait_cnt_nxt = wait_cnt_r;
    sck_nxt      = sck_r;
    mosi_nxt     = mosi_r;
    cs_n_nxt     = cs_n_r;
    rx_valid     = 1'b0;
    dropped      = 1'b0;
    rx_out       = '0;

    if (phase_r == PH_IDLE) begin
      sck_nxt = cfg.clk_mode[1];
      case (req_type)
        spi_mbe_pkg::REQ_BYTE: begin
          mosi_nxt     = tx_byte[spi_mbe_pkg::BYTE_W-1];
          tx_shift_nxt = {tx_byte[spi_mbe_pkg::BYTE_W-2:0], 1'b0};
          rx_shift_nxt = '0;
          bit_idx_nxt  = '0;
          wait_cnt_nxt = delay;
          if (cfg.clk_mode[0]) begin
            sck_nxt   = ~cfg.clk_mode[1];
            phase_nxt = PH_A1_TRAIL;
          end else begin
            phase_nxt = PH_A0_LEAD;
          end
        end
        spi_mbe_pkg::REQ_SEL: begin
          cs_n_nxt     = 1'b0;
          wait_cnt_nxt = delay;
          phase_nxt    = PH_CS_SETUP;
        end
        spi_mbe_pkg::REQ_RELEASE: begin
          wait_cnt_nxt = delay;
          phase_nxt    = PH_CS_HOLD;
        end
        default: begin
        end
      endcase
    end else begin
      dropped = (req_type != spi_mbe_pkg::REQ_IDLE);
      if (wait_cnt_r > spi_mbe_pkg::HALF_W'(1)) begin
        wait_cnt_nxt = wait_cnt_r - spi_mbe_pkg::HALF_W'(1);
      end else begin
        case (phase_r)
          PH_A0_LEAD, PH_A1_TRAIL: begin
            sck_nxt      = ~sck_r;
            rx_shift_nxt = {rx_shift_r[spi_mbe_pkg::BYTE_W-2:0], miso};
            wait_cnt_nxt = delay;
            phase_nxt    = (phase_r == PH_A0_LEAD) ? PH_A0_TRAIL : PH_A1_GAP;
          end
          PH_A0_TRAIL, PH_A1_GAP: begin
            // In mode phase 0 the trailing edge lands here; in phase 1 the
            // next bit's leading edge does, unless the byte is done.
            if (phase_r == PH_A0_TRAIL) begin
              sck_nxt = ~sck_r;
            end
            if (bit_idx_r == LAST_BIT) begin
              rx_valid  = 1'b1;
              rx_out    = rx_shift_r;
              phase_nxt = PH_IDLE;
            end else begin
              if (phase_r == PH_A1_GAP) begin
                sck_nxt = ~sck_r;
              end
              bit_idx_nxt  = bit_idx_r + 3'd1;
              mosi_nxt     = tx_shift_r[spi_mbe_pkg::BYTE_W-1];
              tx_shift_nxt = {tx_shift_r[spi_mbe_pkg::BYTE_W-2:0], 1'b0};
              wait_cnt_nxt = delay;
              phase_nxt    = (phase_r == PH_A0_TRAIL) ? PH_A0_LEAD : PH_A1_TRAIL;
            end
          end
          PH_CS_HOLD: begin
            cs_n_nxt     = 1'b1;
            wait_cnt_nxt = delay;
            phase_nxt    = PH_CS_IDLE;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
        if (phase_nxt == PH_IDLE) begin
          wait_cnt_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_shift_r <= '0;
      rx_shift_r <= '0;
      bit_idx_r  <= '0;
      phase_r    <= PH_IDLE;
      wait_cnt_r <= '0;
      sck_r      <= 1'b0;
      mosi_r     <= 1'b0;
      cs_n_r     <= 1'b1;
    end else if (step_en) begin
      tx_shift_r <= tx_shift_nxt;
      rx_shift_r <= rx_shift_nxt;
      bit_idx_r  <= bit_idx_nxt;
      phase_r    <= phase_nxt;
      wait_cnt_r <= wait_cnt_nxt;
      sck_r      <= sck_nxt;
      mosi_r     <= mosi_nxt;
      cs_n_r     <= cs_n_nxt;
    end
  end

  always_comb begin
    res.sck         = sck_nxt;
    res.mosi        = mosi_nxt;
    res.cs_n        = cs_n_nxt;
    res.busy_res    = (phase_nxt != PH_IDLE);
    res.rx_byte     = rx_out;
    res.rx_valid    = rx_valid;
    res.req_dropped = dropped;
  end

endmodule

>>> sv/spi_mbe_chk.sv
// Port-level checker for the SPI master byte engine and its bind to the top level.
`include "spi_master_byte_engine_top_assert.svh"

module spi_mbe_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_busy_res,
  input logic                           out_rx_valid,
  input logic [spi_mbe_pkg::BYTE_W-1:0] out_rx_byte
);

  // A finished byte ends its sequence on the same tick.
  `SPI_MBE_ASSERT_NOW(a_rx_ends_busy, out_valid && out_rx_valid, !out_busy_res)
  // The received byte reads as zero on beats without a completed byte.
  `SPI_MBE_ASSERT_NOW(a_rx_byte_quiet, out_valid && !out_rx_valid, out_rx_byte == '0)
  // With the result register empty, requests must be taken.
  `SPI_MBE_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
  // A result beat that is not taken stays offered.
  `SPI_MBE_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid)

endmodule

bind spi_master_byte_engine_top spi_mbe_chk u_spi_mbe_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_busy_res (out_ch.busy_res),
  .out_rx_valid (out_ch.rx_valid),
  .out_rx_byte  (out_ch.rx_byte)
);

>>> sim/spi_master_byte_engine_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the SPI master byte engine with a beat-level predictor.
module spi_master_byte_engine_top_test;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_A0_LEAD, SEQ_A0_TRAIL, SEQ_A1_TRAIL,
    SEQ_A1_GAP, SEQ_CS_SETUP, SEQ_CS_HOLD, SEQ_CS_IDLE
  } seq_phase_t;

  logic clk;
  logic rst_n;

  spi_mbe_in_if  in_ch();
  spi_mbe_out_if out_ch();
  spi_mbe_cfg_if cfg_ch();

  spi_master_byte_engine_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow of the configuration registers and of the sequencer.
  logic [1:0]                     mode_shadow;
  logic [spi_mbe_pkg::HALF_W-1:0] half_shadow;
  logic [7:0]                     tx_sr;
  logic [7:0]                     rx_sr;
  logic [2:0]                     bit_num;
  seq_phase_t                     seq_phase;
  logic [spi_mbe_pkg::HALF_W-1:0] tick_wait;
  logic                           sck_lvl;
  logic                           mosi_lvl;
  logic                           csn_lvl;

  spi_mbe_pkg::result_t expected_pins[$];
  spi_mbe_pkg::result_t want;
  int unsigned beats_sent;
  int unsigned beats_checked;
  int unsigned bytes_received;
  int unsigned drops_seen;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [spi_mbe_pkg::HALF_W-1:0] half_delay();
    return (half_shadow == '0) ? spi_mbe_pkg::HALF_W'(1) : half_shadow;
  endfunction

  function automatic void shift_out_bit();
    mosi_lvl = tx_sr[7];
    tx_sr = {tx_sr[6:0], 1'b0};
  endfunction

  // Advances the shadow sequencer by one tick and returns the pins it should show.
  function automatic spi_mbe_pkg::result_t advance_engine_tick(input logic [1:0] req,
                                                               input logic [7:0] txb,
                                                               input logic miso);
    spi_mbe_pkg::result_t pins;
    pins = '0;
    if (seq_phase == SEQ_IDLE) begin
      sck_lvl = mode_shadow[1];
      case (req)
        spi_mbe_pkg::REQ_BYTE: begin
          tx_sr = txb;
          rx_sr = '0;
          bit_num = '0;
          shift_out_bit();
          tick_wait = half_delay();
          if (mode_shadow[0]) begin
            sck_lvl = ~sck_lvl;
            seq_phase = SEQ_A1_TRAIL;
          end else begin
            seq_phase = SEQ_A0_LEAD;
          end
        end
        spi_mbe_pkg::REQ_SEL: begin
          csn_lvl = 1'b0;
          tick_wait = half_delay();
          seq_phase = SEQ_CS_SETUP;
        end
        spi_mbe_pkg::REQ_RELEASE: begin
          tick_wait = half_delay();
          seq_phase = SEQ_CS_HOLD;
        end
        default: ;
      endcase
    end else begin
      pins.req_dropped = (req != spi_mbe_pkg::REQ_IDLE);
      if (tick_wait > spi_mbe_pkg::HALF_W'(1)) begin
        tick_wait = tick_wait - spi_mbe_pkg::HALF_W'(1);
      end else begin
        case (seq_phase)
          SEQ_A0_LEAD: begin
            sck_lvl = ~sck_lvl;
            rx_sr = {rx_sr[6:0], miso};
            tick_wait = half_delay();
            seq_phase = SEQ_A0_TRAIL;
          end
          SEQ_A0_TRAIL: begin
            sck_lvl = ~sck_lvl;
            if (bit_num == 3'd7) begin
              pins.rx_valid = 1'b1;
              pins.rx_byte = rx_sr;
              seq_phase = SEQ_IDLE;
            end else begin
              bit_num = bit_num + 3'd1;
              shift_out_bit();
              tick_wait = half_delay();
              seq_phase = SEQ_A0_LEAD;
            end
          end
          SEQ_A1_TRAIL: begin
            sck_lvl = ~sck_lvl;
            rx_sr = {rx_sr[6:0], miso};
            tick_wait = half_delay();
            seq_phase = SEQ_A1_GAP;
          end
          SEQ_A1_GAP: begin
            if (bit_num == 3'd7) begin
              pins.rx_valid = 1'b1;
              pins.rx_byte = rx_sr;
              seq_phase = SEQ_IDLE;
            end else begin
              bit_num = bit_num + 3'd1;
              sck_lvl = ~sck_lvl;
              shift_out_bit();
              tick_wait = half_delay();
              seq_phase = SEQ_A1_TRAIL;
            end
          end
          SEQ_CS_HOLD: begin
            csn_lvl = 1'b1;
            tick_wait = half_delay();
            seq_phase = SEQ_CS_IDLE;
          end
          default: seq_phase = SEQ_IDLE;
        endcase
        if (seq_phase == SEQ_IDLE) tick_wait = '0;
      end
    end
    pins.sck = sck_lvl;
    pins.mosi = mosi_lvl;
    pins.cs_n = csn_lvl;
    pins.busy_res = (seq_phase != SEQ_IDLE);
    return pins;
  endfunction

  // Sends one request beat, with random idle cycles ahead of it.
  task automatic send_tick(input logic [1:0] req, input logic [7:0] txb, input logic miso);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.req_type = req;
    in_ch.tx_byte = txb;
    in_ch.miso = miso;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_pins.push_back(advance_engine_tick(req, txb, miso));
    beats_sent++;
    @(negedge clk);
  endtask

  // Runs the sequencer out with idle ticks, then waits for every result beat.
  task automatic quiesce();
    while (seq_phase != SEQ_IDLE) send_tick(spi_mbe_pkg::REQ_IDLE, 8'($urandom), 1'($urandom));
    in_ch.valid = 1'b0;
    while (expected_pins.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_engine_reg(input logic [spi_mbe_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [spi_mbe_pkg::HALF_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == spi_mbe_pkg::CFG_IDX_MODE) mode_shadow = value[1:0];
    else half_shadow = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // The unused upper bits of the mode write carry random data.
  task automatic set_engine(input logic [1:0] mode,
                            input logic [spi_mbe_pkg::HALF_W-1:0] half);
    quiesce();
    write_engine_reg(spi_mbe_pkg::CFG_IDX_MODE, {14'($urandom), mode});
    write_engine_reg(spi_mbe_pkg::CFG_IDX_HALF, half);
  endtask

  task automatic check_pin(input string name, input logic [7:0] exp_val,
                           input logic [7:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pins.size() == 0) begin
        $error("result beat arrived with no request beat waiting for it");
        mismatches++;
      end else begin
        want = expected_pins.pop_front();
        check_pin("sck", 8'(want.sck), 8'(out_ch.sck));
        check_pin("mosi", 8'(want.mosi), 8'(out_ch.mosi));
        check_pin("cs_n", 8'(want.cs_n), 8'(out_ch.cs_n));
        check_pin("busy_res", 8'(want.busy_res), 8'(out_ch.busy_res));
        check_pin("rx_byte", want.rx_byte, out_ch.rx_byte);
        check_pin("rx_valid", 8'(want.rx_valid), 8'(out_ch.rx_valid));
        check_pin("req_dropped", 8'(want.req_dropped), 8'(out_ch.req_dropped));
        beats_checked++;
        if (out_ch.rx_valid === 1'b1) bytes_received++;
        if (out_ch.req_dropped === 1'b1) drops_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Pin levels right after reset, then one byte with the reset configuration.
  task automatic test_reset_levels();
    send_tick(spi_mbe_pkg::REQ_IDLE, 8'h00, 1'b0);
    send_tick(spi_mbe_pkg::REQ_IDLE, 8'hFF, 1'b1);
    send_tick(spi_mbe_pkg::REQ_BYTE, 8'hA5, 1'b1);
    quiesce();
  endtask

  // Each mode gets an all-ones and an all-zeros byte; the idle tick shows the new CPOL.
  task automatic test_all_modes();
    for (int m = 0; m < 4; m++) begin
      set_engine(2'(m), 16'd1);
      send_tick(spi_mbe_pkg::REQ_IDLE, 8'h00, 1'b0);
      send_tick(spi_mbe_pkg::REQ_BYTE, 8'hFF, 1'b0);
      quiesce();
      send_tick(spi_mbe_pkg::REQ_BYTE, 8'h00, 1'b1);
      quiesce();
    end
  endtask

  // Select, byte and release requests, with every request type thrown in while busy.
  task automatic test_select_and_drops();
    set_engine(2'd1, 16'd2);
    send_tick(spi_mbe_pkg::REQ_SEL, 8'h3C, 1'b0);
    send_tick(spi_mbe_pkg::REQ_BYTE, 8'hFF, 1'b1);
    send_tick(spi_mbe_pkg::REQ_RELEASE, 8'h00, 1'b0);
    send_tick(spi_mbe_pkg::REQ_SEL, 8'h81, 1'b1);
    quiesce();
    send_tick(spi_mbe_pkg::REQ_BYTE, 8'h5A, 1'b1);
    send_tick(spi_mbe_pkg::REQ_IDLE, 8'h00, 1'b0);
    send_tick(spi_mbe_pkg::REQ_BYTE, 8'h00, 1'b0);
    quiesce();
    send_tick(spi_mbe_pkg::REQ_RELEASE, 8'hC3, 1'b1);
    send_tick(spi_mbe_pkg::REQ_SEL, 8'h00, 1'b0);
    quiesce();
  endtask

  // A half period of zero behaves as one tick.
  task automatic test_zero_delay();
    set_engine(2'd3, 16'd0);
    send_tick(spi_mbe_pkg::REQ_SEL, 8'h00, 1'b0);
    quiesce();
    send_tick(spi_mbe_pkg::REQ_BYTE, 8'hC3, 1'b1);
    quiesce();
    send_tick(spi_mbe_pkg::REQ_RELEASE, 8'h00, 1'b0);
    quiesce();
  endtask

  // A long delay counts down once, on a select setup.
  task automatic test_long_delay();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    set_engine(2'd2, 16'd100);
    send_tick(spi_mbe_pkg::REQ_SEL, 8'hFF, 1'b1);
    quiesce();
    set_engine(2'd0, 16'd1);
    send_tick(spi_mbe_pkg::REQ_RELEASE, 8'h00, 1'b0);
    quiesce();
  endtask

  // Mostly well-formed select, byte and release sequences with noise while busy.
  task automatic test_random_traffic(input int unsigned n_chunk, input int unsigned src_pct,
                                     input int unsigned sink_pct);
    logic [1:0] req;
    int unsigned pick;
    for (int chunk = 0; chunk < 3; chunk++) begin
      set_engine(2'($urandom_range(0, 3)), 16'($urandom_range(0, 4)));
      src_idle_pct = src_pct;
      sink_stall_pct = sink_pct;
      repeat (n_chunk) begin
        pick = $urandom_range(0, 99);
        if (seq_phase == SEQ_IDLE) begin
          if (pick < 50) req = spi_mbe_pkg::REQ_BYTE;
          else if (pick < 65) req = spi_mbe_pkg::REQ_SEL;
          else if (pick < 80) req = spi_mbe_pkg::REQ_RELEASE;
          else req = spi_mbe_pkg::REQ_IDLE;
        end else begin
          req = (pick < 10) ? 2'($urandom_range(1, 3)) : spi_mbe_pkg::REQ_IDLE;
        end
        send_tick(req, 8'($urandom), 1'($urandom));
      end
      quiesce();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = spi_mbe_pkg::REQ_IDLE;
    in_ch.tx_byte = '0;
    in_ch.miso = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = spi_mbe_pkg::CFG_IDX_MODE;
    cfg_ch.data = '0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    beats_sent = 0;
    beats_checked = 0;
    bytes_received = 0;
    drops_seen = 0;
    mismatches = 0;
    cycle_count = 0;
    mode_shadow = 2'd0;
    half_shadow = 16'd1;
    tx_sr = '0;
    rx_sr = '0;
    bit_num = '0;
    seq_phase = SEQ_IDLE;
    tick_wait = '0;
    sck_lvl = 1'b0;
    mosi_lvl = 1'b0;
    csn_lvl = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_levels();
    test_all_modes();
    test_select_and_drops();
    test_zero_delay();
    test_long_delay();
    test_random_traffic(50, 0, 0);
    test_random_traffic(50, 82, 0);
    test_random_traffic(50, 0, 82);
    test_random_traffic(50, 30, 30);

    in_ch.valid = 1'b0;
    while (expected_pins.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Sent %0d request beats over all four SPI modes, half periods 0 to 100,",
             beats_sent);
    $display("and checked %0d result beats with %0d received bytes and %0d dropped requests.",
             beats_checked, bytes_received, drops_seen);
    if (mismatches == 0 && expected_pins.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
